@@ rtl/mlpf_pkg.sv @@
// Package for the MLP forward-pass core: field widths, op and register codes,
// MAC control struct and the elaboration-time sigmoid table builder.
// No dependencies.
package mlpf_pkg;

    localparam int SIZE_W      = 7;
    localparam int LC_W        = 3;
    localparam int FLD_W       = 6;
    localparam int SEL_W       = 2;
    localparam int OP_W        = 2;
    localparam int VAL_W       = 16;
    localparam int SIG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int RESULT_LIMIT    = 64;
    localparam int SIG_MAX_ENTRIES = 4096;

    localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_H1_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H2_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE = 3'd4;

    typedef logic [SIG_MAX_ENTRIES*SIG_W-1:0] t_sig_flat;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    // shift-subtract long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // p_j ~ 2^32*e^(-j/256); entries for +x and -x filled at table stride
    function automatic t_sig_flat sig_table_build(input int bits);
        t_sig_flat   t;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] q;
        int          sh;
        int          stride;
        int          ipos;
        int          ineg;
        t      = '0;
        p      = 64'h1_0000_0000;
        sh     = 12 - bits;
        stride = 1 << sh;
        for (int j = 0; j <= 2048; j++) begin
            d = 64'h1_0000_0000 + p;
            if ((j & (stride - 1)) == 0) begin
                ipos = (2048 + j) >> sh;
                if (ipos < (1 << bits)) begin
                    q = udiv64(64'h1000_0000_0000 + (d >> 1), d);
                    t[ipos*SIG_W +: SIG_W] = q[SIG_W-1:0];
                end
                if (j > 0) begin
                    ineg = (2048 - j) >> sh;
                    q = udiv64((p << 12) + (d >> 1), d);
                    t[ineg*SIG_W +: SIG_W] = q[SIG_W-1:0];
                end
            end
            p = (p * 64'd4278222805 + 64'h8000_0000) >> 32;
        end
        return t;
    endfunction

endpackage

@@ rtl/mlpf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mlpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mlpf_mac.sv @@
// Multiply-accumulate and sigmoid lookup pipeline for one neuron at a time.
// Depends on mlpf_pkg (control struct, sigmoid table builder).
module mlpf_mac #(
    parameter int MAX_NEURONS        = 64,
    parameter int SIGMOID_TABLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mlpf_pkg::t_mac_ctl            i_ctl,
    input  logic signed [15:0]            i_act,
    input  logic signed [15:0]            i_wgt,
    input  logic signed [15:0]            i_bias,
    output logic                          o_sig_valid,
    output logic [mlpf_pkg::SIG_W-1:0]    o_sig
);
    import mlpf_pkg::*;

    localparam int ACC_W = 34 + $clog2(MAX_NEURONS);
    localparam int TB    = SIGMOID_TABLE_BITS;
    localparam t_sig_flat SIG_ROM = sig_table_build(SIGMOID_TABLE_BITS);
    localparam logic signed [ACC_W-1:0] SIG_HI = ACC_W'(64'sd134217728);
    localparam logic signed [ACC_W-1:0] SIG_LO = -SIG_HI;

    t_mac_ctl                  r_ctl2;
    logic signed [31:0]        r_prod;
    logic signed [15:0]        r_bias;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_acc_v;
    logic [TB-1:0]             r_idx;
    logic                      r_idx_v;
    logic [SIG_W-1:0]          r_sig;
    logic                      r_sig_v;
    logic signed [ACC_W-1:0]   w_base;
    logic signed [ACC_W-1:0]   w_shift;
    logic [TB-1:0]             n_idx;

    assign w_base  = r_ctl2.first ? {{(ACC_W-28){r_bias[15]}}, r_bias, 12'b0} : r_acc;
    assign w_shift = r_acc + SIG_HI;

    always_comb begin
        if (r_acc < SIG_LO) begin
            n_idx = '0;
        end else if (r_acc >= SIG_HI) begin
            n_idx = '1;
        end else begin
            n_idx = w_shift[27 -: TB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2  <= '0;
            r_acc_v <= 1'b0;
            r_idx_v <= 1'b0;
            r_sig_v <= 1'b0;
        end else begin
            r_ctl2  <= i_ctl;
            r_acc_v <= r_ctl2.valid & r_ctl2.last;
            r_idx_v <= r_acc_v;
            r_sig_v <= r_idx_v;
        end
        r_prod <= i_act * i_wgt;
        r_bias <= i_bias;
        if (r_ctl2.valid) begin
            r_acc <= w_base + {{(ACC_W-32){r_prod[31]}}, r_prod};
        end
        r_idx <= n_idx;
        r_sig <= SIG_ROM[int'(r_idx)*SIG_W +: SIG_W];
    end

    assign o_sig_valid = r_sig_v;
    assign o_sig       = r_sig;
endmodule

@@ rtl/mlp_forward_pass_core.sv @@
// Top level of the MLP forward-pass core: request decode, config registers,
// layer sequencer and store RAMs. Depends on mlpf_pkg, mlpf_ram, mlpf_mac.
//
// Fully connected sigmoid network, three or four layers, Q4.12 data. Each
// request (i_start while o_busy is low) writes one weight, one bias or one
// pattern element. A pattern element with i_pattern_end set starts a forward
// pass and raises o_busy; one shared MAC walks every neuron, reading
// activation, weight and bias from the store RAMs one source per cycle.
// The results arrive one per output neuron in index order, each on
// o_result_valid for one cycle; they cannot be held off, so the receiver
// must take every strobe. The final strobe has o_last_out set and is up in
// the first cycle with o_busy low. Configuration must be written through
// the i_cfg_* port only while o_busy is low; the user is bound by this, as
// the block itself does not enforce it.
module mlp_forward_pass_core #(
    parameter int MAX_NEURONS        = 64,
    parameter int MAX_LAYERS         = 4,
    parameter int SIGMOID_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [mlpf_pkg::OP_W-1:0]           i_op,
    input  logic [mlpf_pkg::SEL_W-1:0]          i_layer_sel,
    input  logic [mlpf_pkg::FLD_W-1:0]          i_row,
    input  logic [mlpf_pkg::FLD_W-1:0]          i_col,
    input  logic signed [mlpf_pkg::VAL_W-1:0]   i_value,
    input  logic                                i_pattern_end,
    input  logic                                i_cfg_we,
    input  logic [mlpf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mlpf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_result_valid,
    output logic [mlpf_pkg::FLD_W-1:0]          o_neuron_index,
    output logic [mlpf_pkg::SIG_W-1:0]          o_activation,
    output logic                                o_last_out
);
    import mlpf_pkg::*;

    localparam int NL_W   = MAX_LAYERS - 1;
    localparam int WDEPTH = NL_W * MAX_NEURONS * MAX_NEURONS;
    localparam int BDEPTH = NL_W * MAX_NEURONS;
    localparam int ADEPTH = 2 * MAX_NEURONS;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int BA_W   = $clog2(BDEPTH);
    localparam int AA_W   = $clog2(ADEPTH);
    localparam int OUT_LIM = (MAX_NEURONS < RESULT_LIMIT) ? MAX_NEURONS : RESULT_LIMIT;
    localparam logic FOUR_OK = (MAX_LAYERS >= 4);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    function automatic logic [SIZE_W-1:0] clamp_sz(input logic [SIZE_W-1:0] s,
                                                   input int lim);
        if (s == '0) begin
            return SIZE_W'(1);
        end else if (int'(s) > lim) begin
            return SIZE_W'(lim);
        end
        return s;
    endfunction

    // config registers
    logic [LC_W-1:0]   r_layer_count;
    logic [SIZE_W-1:0] r_input_size;
    logic [SIZE_W-1:0] r_h1_size;
    logic [SIZE_W-1:0] r_h2_size;
    logic [SIZE_W-1:0] r_output_size;

    // sequencer
    logic [1:0]        r_state;
    logic [SEL_W-1:0]  r_sel;
    logic              r_src;
    logic [SIZE_W-1:0] r_i;
    logic [SIZE_W-1:0] r_j;
    t_mac_ctl          r_ctl1;

    logic              r_out_valid;
    logic [FLD_W-1:0]  r_out_idx;
    logic [SIG_W-1:0]  r_out_act;
    logic              r_out_last;

    logic              w_four;
    logic [SIZE_W-1:0] w_n_in, w_n_h1, w_n_h2, w_n_out;
    logic [SIZE_W-1:0] w_nsrc, w_ndst;
    logic              w_is_out;
    logic              w_accept;
    logic              w_sel_ok, w_row_ok, w_col_ok;
    logic              w_last_src, w_last_dst;
    t_mac_ctl          w_ctl0;

    logic              w_wgt_we;
    logic [WA_W-1:0]   w_wgt_waddr, w_wgt_raddr;
    logic              w_bias_we;
    logic [BA_W-1:0]   w_bias_waddr, w_bias_raddr;
    logic              w_act_we;
    logic [AA_W-1:0]   w_act_waddr, w_act_raddr;
    logic [VAL_W-1:0]  w_act_wdata;
    logic [VAL_W-1:0]  w_wgt_rdata, w_bias_rdata, w_act_rdata;
    logic              w_sig_valid;
    logic [SIG_W-1:0]  w_sig;
    logic              w_wb;

    // layer geometry
    assign w_four  = FOUR_OK && (r_layer_count >= 3'd4);
    assign w_n_in  = clamp_sz(r_input_size, MAX_NEURONS);
    assign w_n_h1  = clamp_sz(r_h1_size, MAX_NEURONS);
    assign w_n_h2  = clamp_sz(r_h2_size, MAX_NEURONS);
    assign w_n_out = clamp_sz(r_output_size, OUT_LIM);
    assign w_is_out = w_four ? (r_sel == 2'd2) : (r_sel == 2'd1);

    always_comb begin
        case (r_sel)
            2'd0:    w_nsrc = w_n_in;
            2'd1:    w_nsrc = w_n_h1;
            default: w_nsrc = w_n_h2;
        endcase
        if (r_sel == 2'd0) begin
            w_ndst = w_n_h1;
        end else if (w_is_out) begin
            w_ndst = w_n_out;
        end else begin
            w_ndst = w_n_h2;
        end
    end

    assign w_last_src = (r_j == w_nsrc - SIZE_W'(1));
    assign w_last_dst = (r_i == w_ndst - SIZE_W'(1));

    // request decode; out-of-range writes are dropped
    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_sel_ok = int'(i_layer_sel) < NL_W;
    assign w_row_ok = int'(i_row) < MAX_NEURONS;
    assign w_col_ok = int'(i_col) < MAX_NEURONS;

    assign w_wgt_we    = w_accept && (i_op == OP_WEIGHT) && w_sel_ok && w_row_ok && w_col_ok;
    assign w_wgt_waddr = WA_W'((int'(i_layer_sel) * MAX_NEURONS + int'(i_row)) * MAX_NEURONS
                               + int'(i_col));
    assign w_bias_we    = w_accept && (i_op == OP_BIAS) && w_sel_ok && w_row_ok;
    assign w_bias_waddr = BA_W'(int'(i_layer_sel) * MAX_NEURONS + int'(i_row));

    // activation store: pattern load while idle, neuron writeback during a pass
    assign w_wb = (r_state == S_WAIT) && w_sig_valid && !w_is_out;
    always_comb begin
        if (w_wb) begin
            w_act_we    = 1'b1;
            w_act_waddr = AA_W'(int'(!r_src) * MAX_NEURONS + int'(r_i));
            w_act_wdata = VAL_W'(w_sig);
        end else begin
            w_act_we    = w_accept && (i_op == OP_PATTERN) && w_col_ok;
            w_act_waddr = AA_W'(int'(i_col));
            w_act_wdata = i_value;
        end
    end

    // read side follows the sequencer
    assign w_wgt_raddr  = WA_W'((int'(r_sel) * MAX_NEURONS + int'(r_i)) * MAX_NEURONS
                                + int'(r_j));
    assign w_bias_raddr = BA_W'(int'(r_sel) * MAX_NEURONS + int'(r_i));
    assign w_act_raddr  = AA_W'(int'(r_src) * MAX_NEURONS + int'(r_j));

    assign w_ctl0.valid = (r_state == S_RUN);
    assign w_ctl0.first = (r_j == '0);
    assign w_ctl0.last  = w_last_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 3'd3;
            r_input_size  <= 7'd64;
            r_h1_size     <= 7'd64;
            r_h2_size     <= 7'd64;
            r_output_size <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAYER_COUNT: r_layer_count <= i_cfg_wdata[LC_W-1:0];
                CFG_INPUT_SIZE:  r_input_size  <= i_cfg_wdata;
                CFG_H1_SIZE:     r_h1_size     <= i_cfg_wdata;
                CFG_H2_SIZE:     r_h2_size     <= i_cfg_wdata;
                CFG_OUTPUT_SIZE: r_output_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= '0;
            r_src       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_ctl1      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ctl1      <= w_ctl0;
            r_out_valid <= (r_state == S_WAIT) && w_sig_valid && w_is_out;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_op == OP_PATTERN) && i_pattern_end) begin
                        r_state <= S_RUN;
                        r_sel   <= '0;
                        r_src   <= 1'b0;
                        r_i     <= '0;
                        r_j     <= '0;
                    end
                end
                S_RUN: begin
                    if (w_last_src) begin
                        r_j     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_j <= r_j + SIZE_W'(1);
                    end
                end
                S_WAIT: begin
                    if (w_sig_valid) begin
                        if (w_last_dst) begin
                            if (w_is_out) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_sel   <= r_sel + SEL_W'(1);
                                r_src   <= ~r_src;
                                r_i     <= '0;
                                r_state <= S_RUN;
                            end
                        end else begin
                            r_i     <= r_i + SIZE_W'(1);
                            r_state <= S_RUN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        r_out_idx  <= r_i[FLD_W-1:0];
        r_out_act  <= w_sig;
        r_out_last <= w_last_dst;
    end

    mlpf_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (w_wgt_waddr),
        .i_wdata (i_value),
        .i_raddr (w_wgt_raddr),
        .o_rdata (w_wgt_rdata)
    );

    mlpf_ram #(.WIDTH(VAL_W), .DEPTH(BDEPTH)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_bias_we),
        .i_waddr (w_bias_waddr),
        .i_wdata (i_value),
        .i_raddr (w_bias_raddr),
        .o_rdata (w_bias_rdata)
    );

    mlpf_ram #(.WIDTH(VAL_W), .DEPTH(ADEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (w_act_waddr),
        .i_wdata (w_act_wdata),
        .i_raddr (w_act_raddr),
        .o_rdata (w_act_rdata)
    );

    mlpf_mac #(
        .MAX_NEURONS        (MAX_NEURONS),
        .SIGMOID_TABLE_BITS (SIGMOID_TABLE_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl1),
        .i_act       (w_act_rdata),
        .i_wgt       (w_wgt_rdata),
        .i_bias      (w_bias_rdata),
        .o_sig_valid (w_sig_valid),
        .o_sig       (w_sig)
    );

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_neuron_index = r_out_idx;
    assign o_activation   = r_out_act;
    assign o_last_out     = r_out_last;

`ifndef SYNTHESIS
    a_last_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last_out |-> !o_busy)
        else $error("last result while pass still running");
    a_sig_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sig_valid |-> (r_state == S_WAIT))
        else $error("neuron result outside wait state");
    a_pass_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_op == OP_PATTERN) && i_pattern_end |=> o_busy)
        else $error("pattern end did not start a pass");
`endif
endmodule
